// ===== hw/rtl/imst_pkg.sv =====
// Shared constants and types for the indentation margin stack tokenizer.
`default_nettype none

package imst_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MARGIN_BITS = 8;

	localparam int IN_W       = 8;
	localparam int TDATA_W    = 8;
	localparam int KIND_W     = 3;
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W      = $clog2(STACK_DEPTH);
	localparam int CMP_W      = 16;
	localparam int MARGIN_MAX = (1 << MARGIN_BITS) - 1;

	typedef enum logic [KIND_W-1:0] {
		TK_EOL          = 3'd0,
		TK_INDENT       = 3'd1,
		TK_DEDENT       = 3'd2,
		TK_ERR_INDENT   = 3'd3,
		TK_ERR_OVERFLOW = 3'd4
	} token_kind_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indent_margin_stack_tokenizer_unit.sv =====
// Indentation margin stack tokenizer: line margins in, layout tokens out.
//
//   channel | dir | words                 | accepted when
//   s_*     | in  | one per source line   | s_tvalid && s_tready
//   m_*     | out | 0..N tokens per line  | m_tvalid && m_tready
//
// A line is accepted in S_IDLE, then makes one pass through the margin compare.
// A line that closes k margins runs S_CMP then S_POP once per closed margin:
// each close is a compare plus an EOL step, all through the single margin comparator.
// Each token waits for the one-word output register to drain.
// Reset leaves only the base margin 0 on the stack; no clearing pass.
// After an error every further line is accepted and dropped until reset.
`default_nettype none

module indent_margin_stack_tokenizer_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [imst_pkg::TDATA_W-1:0] s_tdata,  // [7:0] indent_width
	input  wire logic                        s_tuser,   // [0] after_colon
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [imst_pkg::TDATA_W-1:0]     m_tdata,   // [2:0] token_kind, rest zero
	output logic                             m_tlast    // last_token
);
	import imst_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_POP
	} state_t;

	state_t                 state_q;
	logic [CNT_W-1:0]       count_q;
	logic                   err_q;
	logic [MARGIN_BITS-1:0] n_q;
	logic                   colon_q;
	logic                   out_valid_q;
	token_kind_t            out_kind_q;
	logic                   out_last_q;

	logic [MARGIN_BITS-1:0] margin_q [STACK_DEPTH];
	logic                   real_q   [STACK_DEPTH];

	logic [MARGIN_BITS-1:0] n_sat;
	logic [IDX_W-1:0]       top_idx;
	logic [MARGIN_BITS-1:0] top_margin;
	logic                   top_real;
	logic                   is_eq;
	logic                   is_gt;
	logic                   is_lt;
	logic                   full;
	logic                   more;
	logic                   slot_free;
	logic                   push_en;
	logic                   emit_en;
	token_kind_t            emit_kind;
	logic                   emit_last;
	logic                   set_err;
	logic                   cnt_inc;
	logic                   cnt_dec;
	state_t                 state_d;

	always_comb begin
		if ({{(CMP_W-IN_W){1'b0}}, s_tdata[IN_W-1:0]} > CMP_W'(MARGIN_MAX)) begin
			n_sat = MARGIN_BITS'(MARGIN_MAX);
		end else begin
			n_sat = MARGIN_BITS'(s_tdata[IN_W-1:0]);
		end
	end

	// shared margin comparator against the top of stack
	assign top_idx = IDX_W'(count_q - CNT_W'(1));
	always_comb begin
		if (top_idx == '0) begin
			top_margin = '0;
			top_real   = 1'b1;
		end else begin
			top_margin = margin_q[top_idx];
			top_real   = real_q[top_idx];
		end
	end
	assign is_eq     = (n_q == top_margin);
	assign is_gt     = (n_q > top_margin);
	assign is_lt     = !is_eq && !is_gt;
	assign full      = (count_q >= CNT_W'(STACK_DEPTH));
	assign more      = (count_q > CNT_W'(1)) && is_lt;
	assign slot_free = !out_valid_q || m_tready;

	always_comb begin
		push_en   = 1'b0;
		emit_en   = 1'b0;
		emit_kind = TK_EOL;
		emit_last = 1'b1;
		set_err   = 1'b0;
		cnt_inc   = 1'b0;
		cnt_dec   = 1'b0;
		state_d   = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && !err_q) begin
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (slot_free) begin
					state_d = S_IDLE;
					if (is_eq) begin
						if (colon_q) begin
							emit_en   = 1'b1;
							emit_kind = TK_ERR_INDENT;
							set_err   = 1'b1;
						end else if (top_real) begin
							emit_en = 1'b1;
						end
					end else if (is_gt) begin
						if (full) begin
							emit_en   = 1'b1;
							emit_kind = TK_ERR_OVERFLOW;
							set_err   = 1'b1;
						end else begin
							push_en   = 1'b1;
							cnt_inc   = 1'b1;
							emit_en   = colon_q;
							emit_kind = TK_INDENT;
						end
					end else if (colon_q) begin
						emit_en   = 1'b1;
						emit_kind = TK_ERR_INDENT;
						set_err   = 1'b1;
					end else begin
						emit_en   = top_real;
						emit_kind = TK_DEDENT;
						emit_last = 1'b0;
						cnt_dec   = 1'b1;
						state_d   = S_POP;
					end
				end
			end
			S_POP: begin
				if (slot_free) begin
					emit_en   = 1'b1;
					emit_last = !more;
					state_d   = more ? S_CMP : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= CNT_W'(1);
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_err) begin
				err_q <= 1'b1;
			end
			if (cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (emit_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			n_q     <= n_sat;
			colon_q <= s_tuser;
		end
		if (emit_en) begin
			out_kind_q <= emit_kind;
			out_last_q <= emit_last;
		end
		if (push_en) begin
			margin_q[count_q[IDX_W-1:0]] <= n_q;
			real_q[count_q[IDX_W-1:0]]   <= colon_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-KIND_W){1'b0}}, out_kind_q};
	assign m_tlast  = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) && (count_q <= CNT_W'(STACK_DEPTH)))
		else $error("stack count out of range");

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q && state_q == S_IDLE) |=> (state_q == S_IDLE))
		else $error("sequencer left idle after error");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_kind_q == TK_ERR_INDENT || out_kind_q == TK_ERR_OVERFLOW))
		|-> m_tlast)
		else $error("error token not last");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_CMP))
		else $error("stack count changed outside compare step");

endmodule

`default_nettype wire

// ===== test/tb_indent_margin_stack_tokenizer_unit.sv =====
// Self-checking testbench for the indentation margin stack tokenizer unit.
module tb_indent_margin_stack_tokenizer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import imst_pkg::*;

	localparam int RANDOM_LINES = 240;
	localparam int DRAIN_CYCLES = 4 * STACK_DEPTH + 16;
	localparam int CYCLE_LIMIT  = 1000000;

	typedef struct packed {
		token_kind_t kind;
		logic        last;
	} token_t;

	typedef enum {BY_MODEL, ONE_TOKEN, NO_TOKEN} row_check_t;

	typedef struct {
		logic [7:0]  width;
		bit          colon;
		row_check_t  how;
		token_kind_t kind;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;  // [7:0] indent_width
	logic               s_tuser = 1'b0;  // [0] after_colon
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;  // [2:0] token_kind
	logic               m_tlast;

	// shadow of the margin stack
	logic [MARGIN_BITS-1:0] lvl_margin [STACK_DEPTH];
	bit                     lvl_real [STACK_DEPTH];
	int                     lvl_count;
	bit                     sticky_err;

	token_t pending [$];
	int     errors = 0;
	int     cycles = 0;
	bit     calm = 1'b0;

	script_row_t script [20] = '{
		'{8'd0,   1'b0, ONE_TOKEN, TK_EOL},
		'{8'd4,   1'b1, ONE_TOKEN, TK_INDENT},
		'{8'd4,   1'b0, ONE_TOKEN, TK_EOL},
		'{8'd8,   1'b0, NO_TOKEN,  TK_EOL},
		'{8'd8,   1'b0, NO_TOKEN,  TK_EOL},
		'{8'd255, 1'b1, ONE_TOKEN, TK_INDENT},
		'{8'd255, 1'b0, ONE_TOKEN, TK_EOL},
		'{8'd6,   1'b0, BY_MODEL,  TK_EOL},
		'{8'd4,   1'b0, ONE_TOKEN, TK_EOL},
		'{8'd12,  1'b1, ONE_TOKEN, TK_INDENT},
		'{8'd20,  1'b1, ONE_TOKEN, TK_INDENT},
		'{8'd28,  1'b0, NO_TOKEN,  TK_EOL},
		'{8'd0,   1'b0, BY_MODEL,  TK_EOL},
		'{8'd0,   1'b0, ONE_TOKEN, TK_EOL},
		'{8'd1,   1'b1, ONE_TOKEN, TK_INDENT},
		'{8'd128, 1'b0, NO_TOKEN,  TK_EOL},
		'{8'd170, 1'b1, ONE_TOKEN, TK_INDENT},
		'{8'd85,  1'b0, BY_MODEL,  TK_EOL},
		'{8'd1,   1'b0, ONE_TOKEN, TK_EOL},
		'{8'd0,   1'b0, BY_MODEL,  TK_EOL}
	};

	indent_margin_stack_tokenizer_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// alternate between idling and back-to-back stretches
	initial begin
		forever begin
			repeat ($urandom_range(30, 120)) @(posedge clk);
			calm = ~calm;
		end
	end

	task automatic stack_reset();
		foreach (lvl_margin[i]) begin
			lvl_margin[i] = '0;
			lvl_real[i] = 1'b0;
		end
		lvl_real[0] = 1'b1;
		lvl_count = 1;
		sticky_err = 1'b0;
	endtask

	// tokens one line yields; queued only when keep is set
	task automatic predict_line(input logic [7:0] w, input bit colon, input bit keep);
		token_t toks [$];
		int     t;
		int     m;
		if (sticky_err)
			return;
		m = (w > MARGIN_MAX) ? MARGIN_MAX : w;
		t = lvl_count - 1;
		if (m == lvl_margin[t]) begin
			if (colon) begin
				sticky_err = 1'b1;
				toks.insert(toks.size(), token_t'{TK_ERR_INDENT, 1'b0});
			end else if (lvl_real[t]) begin
				toks.insert(toks.size(), token_t'{TK_EOL, 1'b0});
			end
		end else if (m > lvl_margin[t]) begin
			if (lvl_count >= STACK_DEPTH) begin
				sticky_err = 1'b1;
				toks.insert(toks.size(), token_t'{TK_ERR_OVERFLOW, 1'b0});
			end else begin
				lvl_margin[lvl_count] = m[MARGIN_BITS-1:0];
				lvl_real[lvl_count] = colon;
				lvl_count++;
				if (colon)
					toks.insert(toks.size(), token_t'{TK_INDENT, 1'b0});
			end
		end else if (colon) begin
			sticky_err = 1'b1;
			toks.insert(toks.size(), token_t'{TK_ERR_INDENT, 1'b0});
		end else begin
			while (lvl_count > 1 && m < lvl_margin[lvl_count-1]) begin
				if (lvl_real[lvl_count-1])
					toks.insert(toks.size(), token_t'{TK_DEDENT, 1'b0});
				toks.insert(toks.size(), token_t'{TK_EOL, 1'b0});
				lvl_margin[lvl_count-1] = '0;
				lvl_real[lvl_count-1] = 1'b0;
				lvl_count--;
			end
		end
		if (toks.size() > 0)
			toks[toks.size()-1].last = 1'b1;
		if (keep)
			foreach (toks[i])
				pending.insert(pending.size(), toks[i]);
	endtask

	task automatic send_line(input logic [7:0] w, input bit colon, input row_check_t how,
			input token_kind_t kind);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		s_tuser <= colon;
		do @(posedge clk); while (!s_tready);
		predict_line(w, colon, how == BY_MODEL);
		if (how == ONE_TOKEN)
			pending.insert(pending.size(), token_t'{kind, 1'b1});
	endtask

	function automatic logic [7:0] pick_wider(input int t);
		if ($urandom_range(0, 1) == 0)
			return 8'(t + $urandom_range(1, (255 - t < 6) ? 255 - t : 6));
		return 8'($urandom_range(t + 1, 255));
	endfunction

	// token side
	initial begin
		int     stall;
		token_t want;
		@(posedge arst_n);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: word with none pending: expected nothing, got tdata %h tlast %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = pending.pop_front();
				if (m_tdata !== TDATA_W'(want.kind) || m_tlast !== want.last) begin
					errors++;
					$display("%0t: expected kind %0d last %b, got tdata %h tlast %b",
						$time, want.kind, want.last, m_tdata, m_tlast);
				end
			end
		end
	end

	// line side
	initial begin
		int         n;
		int         pick;
		int         top;
		int         fault;
		bit         roomy;
		bit         dive;
		logic [7:0] w;
		bit         c;
		stack_reset();
		dive = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		foreach (script[i])
			send_line(script[i].width, script[i].colon, script[i].how, script[i].kind);

		// well-formed lines only: no error may occur before the tail
		for (n = 0; n < RANDOM_LINES; n++) begin
			top = lvl_margin[lvl_count-1];
			roomy = lvl_count < STACK_DEPTH && top < 255;
			pick = $urandom_range(0, 99);
			if (!dive && pick >= 95)
				dive = 1'b1;
			if (dive) begin
				if (roomy) begin
					w = 8'(top + $urandom_range(1, (255 - top < 4) ? 255 - top : 4));
					c = 1'b1;
				end else begin
					w = 8'd0;
					c = 1'b0;
					dive = 1'b0;
				end
			end else if (pick < 45 && roomy) begin
				w = pick_wider(top);
				c = pick < 30;
			end else if (pick < 65 || top == 0) begin
				w = 8'(top);
				c = 1'b0;
			end else if (pick < 90) begin
				if ($urandom_range(0, 1) == 0)
					w = lvl_margin[$urandom_range(0, lvl_count - 2)];
				else
					w = 8'($urandom_range(0, top - 1));
				c = 1'b0;
			end else begin
				w = 8'($urandom_range(0, 255));
				c = 1'b0;
				if (w > top && lvl_count >= STACK_DEPTH)
					w = 8'(top);
			end
			send_line(w, c, BY_MODEL, TK_EOL);
		end

		// one sticky fault, then lines that must be dropped
		fault = $urandom_range(0, 2);
		top = lvl_margin[lvl_count-1];
		if (fault == 0) begin
			send_line(8'(top), 1'b1, BY_MODEL, TK_EOL);
		end else if (fault == 1) begin
			if (top == 0) begin
				send_line(8'($urandom_range(1, 255)), 1'b0, BY_MODEL, TK_EOL);
				top = lvl_margin[lvl_count-1];
			end
			send_line(8'($urandom_range(0, top - 1)), 1'b1, BY_MODEL, TK_EOL);
		end else begin
			send_line(8'd0, 1'b0, BY_MODEL, TK_EOL);
			while (lvl_count < STACK_DEPTH)
				send_line(8'(lvl_margin[lvl_count-1] + 1), 1'($urandom_range(0, 1)), BY_MODEL,
					TK_EOL);
			send_line(pick_wider(lvl_margin[lvl_count-1]), 1'($urandom_range(0, 1)), BY_MODEL,
				TK_EOL);
		end
		repeat (6)
			send_line(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), BY_MODEL, TK_EOL);
		s_tvalid <= 1'b0;

		while (pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/imst_pkg.sv
hw/rtl/indent_margin_stack_tokenizer_unit.sv
test/tb_indent_margin_stack_tokenizer_unit.sv
